>>> rtl/cll_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cll_pkg
// Shared types, constants and helpers of the cursor linked-list engine.
// ----------------------------------------------------------------------------
package cll_pkg;

	localparam int CELLS  = 128;
	localparam int IDX_W  = 7;
	localparam int DATA_W = 32;
	localparam int CNT_W  = IDX_W + 1;

	localparam logic [2:0] KIND_NEW     = 3'd0;
	localparam logic [2:0] KIND_INSERT  = 3'd1;
	localparam logic [2:0] KIND_DELETE  = 3'd2;
	localparam logic [2:0] KIND_FIND    = 3'd3;
	localparam logic [2:0] KIND_PREV    = 3'd4;
	localparam logic [2:0] KIND_INSPECT = 3'd5;

	typedef struct packed {
		logic [2:0]               kind;
		logic signed [DATA_W-1:0] value;
		logic [IDX_W-1:0]         list_head;
		logic [IDX_W-1:0]         position;
	} req_word_t;

	typedef struct packed {
		logic [IDX_W-1:0]         cell_index;
		logic signed [DATA_W-1:0] cell_value;
		logic                     is_last;
		logic                     out_of_space;
		logic                     removed;
	} rsp_word_t;

	typedef struct packed {
		logic [IDX_W-1:0] rd_addr;
		logic             wr_en;
		logic [IDX_W-1:0] wr_addr;
		logic [IDX_W-1:0] wr_data;
	} link_req_t;

	typedef struct packed {
		logic [IDX_W-1:0]  rd_addr;
		logic              wr_en;
		logic [IDX_W-1:0]  wr_addr;
		logic [DATA_W-1:0] wr_data;
	} val_req_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_ALLOC_RD,
		ST_ALLOC_CHK,
		ST_ALLOC_POP,
		ST_NEW_LINK,
		ST_INS_RDPOS,
		ST_INS_LINK,
		ST_INS_HOOK,
		ST_WALK_HEAD,
		ST_WALK_FIRST,
		ST_WALK_CMP,
		ST_DEL_BYPASS,
		ST_DEL_RD0,
		ST_DEL_FREE,
		ST_DEL_PUSH,
		ST_INSPECT_RD,
		ST_INSPECT_RES,
		ST_FIN
	} state_t;

	// link of a cell that has not been written since reset
	function automatic logic [IDX_W-1:0] reset_link(input logic [IDX_W-1:0] idx);
		logic [IDX_W-1:0] nxt;
		nxt = '0;
		if (idx != IDX_W'(CELLS - 1)) begin
			nxt = idx + 1'b1;
		end
		return nxt;
	endfunction

endpackage
`default_nettype wire

>>> rtl/cll_link_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cll_link_mem
// Next-link store: one write and one registered read per cycle; per-entry
// valid bits give the reset chain until an entry is first written.
// ----------------------------------------------------------------------------
module cll_link_mem (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire cll_pkg::link_req_t      req,
	output logic [cll_pkg::IDX_W-1:0]    rd_data
);

	logic [cll_pkg::IDX_W-1:0] link_store [cll_pkg::CELLS];
	logic [cll_pkg::CELLS-1:0] valid_q;
	logic [cll_pkg::IDX_W-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			link_store[req.wr_addr] <= req.wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (req.wr_en) begin
			valid_q[req.wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_q[req.rd_addr]) begin
			rd_q <= link_store[req.rd_addr];
		end else begin
			rd_q <= cll_pkg::reset_link(req.rd_addr);
		end
	end

	assign rd_data = rd_q;

endmodule
`default_nettype wire

>>> rtl/cll_value_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cll_value_mem
// Element value store: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module cll_value_mem (
	input  wire logic                    clk,
	input  wire cll_pkg::val_req_t       req,
	output logic [cll_pkg::DATA_W-1:0]   rd_data
);

	logic [cll_pkg::DATA_W-1:0] value_store [cll_pkg::CELLS];
	logic [cll_pkg::DATA_W-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			value_store[req.wr_addr] <= req.wr_data;
		end
		rd_q <= value_store[req.rd_addr];
	end

	assign rd_data = rd_q;

endmodule
`default_nettype wire

>>> rtl/cll_walk_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cll_walk_ctrl
// Request sequencer: allocation, insert, delete, list walk with one shared
// value compare per visited cell, and cell inspection.
// ----------------------------------------------------------------------------
module cll_walk_ctrl (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    accept,
	input  wire cll_pkg::req_word_t      req,
	input  wire logic [cll_pkg::IDX_W-1:0]  link_rd,
	input  wire logic [cll_pkg::DATA_W-1:0] val_rd,
	input  wire logic                    res_free,
	output cll_pkg::link_req_t           link_req,
	output cll_pkg::val_req_t            val_req,
	output logic                         busy,
	output logic                         fin,
	output cll_pkg::rsp_word_t           res
);

	cll_pkg::state_t state_q, state_d;

	logic [2:0]                 kind_q;
	logic [cll_pkg::DATA_W-1:0] value_q;
	logic [cll_pkg::IDX_W-1:0]  head_q;
	logic [cll_pkg::IDX_W-1:0]  pos_q;
	logic [cll_pkg::IDX_W-1:0]  cand_q;
	logic [cll_pkg::IDX_W-1:0]  pred_q;
	logic [cll_pkg::IDX_W-1:0]  tail_q;
	logic [cll_pkg::CNT_W-1:0]  cnt_q;
	cll_pkg::rsp_word_t         res_q;

	logic hit;
	logic runaway;
	logic link_zero;

	assign hit       = (val_rd == value_q);
	assign runaway   = (cnt_q == cll_pkg::CNT_W'(cll_pkg::CELLS));
	assign link_zero = (link_rd == '0);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			cll_pkg::ST_IDLE: begin
				if (accept) begin
					case (req.kind)
						cll_pkg::KIND_NEW,
						cll_pkg::KIND_INSERT:  state_d = cll_pkg::ST_ALLOC_RD;
						cll_pkg::KIND_DELETE,
						cll_pkg::KIND_FIND,
						cll_pkg::KIND_PREV:    state_d = cll_pkg::ST_WALK_HEAD;
						cll_pkg::KIND_INSPECT: state_d = cll_pkg::ST_INSPECT_RD;
						default:               state_d = cll_pkg::ST_FIN;
					endcase
				end
			end
			cll_pkg::ST_ALLOC_RD:  state_d = cll_pkg::ST_ALLOC_CHK;
			cll_pkg::ST_ALLOC_CHK: begin
				state_d = link_zero ? cll_pkg::ST_FIN : cll_pkg::ST_ALLOC_POP;
			end
			cll_pkg::ST_ALLOC_POP: begin
				state_d = (kind_q == cll_pkg::KIND_NEW) ? cll_pkg::ST_NEW_LINK
					: cll_pkg::ST_INS_RDPOS;
			end
			cll_pkg::ST_NEW_LINK:   state_d = cll_pkg::ST_FIN;
			cll_pkg::ST_INS_RDPOS:  state_d = cll_pkg::ST_INS_LINK;
			cll_pkg::ST_INS_LINK:   state_d = cll_pkg::ST_INS_HOOK;
			cll_pkg::ST_INS_HOOK:   state_d = cll_pkg::ST_FIN;
			cll_pkg::ST_WALK_HEAD:  state_d = cll_pkg::ST_WALK_FIRST;
			cll_pkg::ST_WALK_FIRST: begin
				state_d = link_zero ? cll_pkg::ST_FIN : cll_pkg::ST_WALK_CMP;
			end
			cll_pkg::ST_WALK_CMP: begin
				if (hit) begin
					state_d = (kind_q == cll_pkg::KIND_DELETE) ? cll_pkg::ST_DEL_BYPASS
						: cll_pkg::ST_FIN;
				end else if (runaway || link_zero) begin
					state_d = cll_pkg::ST_FIN;
				end
			end
			cll_pkg::ST_DEL_BYPASS:  state_d = cll_pkg::ST_DEL_RD0;
			cll_pkg::ST_DEL_RD0:     state_d = cll_pkg::ST_DEL_FREE;
			cll_pkg::ST_DEL_FREE:    state_d = cll_pkg::ST_DEL_PUSH;
			cll_pkg::ST_DEL_PUSH:    state_d = cll_pkg::ST_FIN;
			cll_pkg::ST_INSPECT_RD:  state_d = cll_pkg::ST_INSPECT_RES;
			cll_pkg::ST_INSPECT_RES: state_d = cll_pkg::ST_FIN;
			cll_pkg::ST_FIN: begin
				if (res_free) begin
					state_d = cll_pkg::ST_IDLE;
				end
			end
			default: state_d = cll_pkg::ST_IDLE;
		endcase
	end

	// memory requests and handshake outputs
	always_comb begin
		link_req = '0;
		val_req  = '0;
		fin      = 1'b0;
		busy     = (state_q != cll_pkg::ST_IDLE);
		case (state_q)
			cll_pkg::ST_ALLOC_CHK: begin
				link_req.rd_addr = link_rd;
			end
			cll_pkg::ST_ALLOC_POP: begin
				link_req.wr_en   = 1'b1;
				link_req.wr_data = link_rd;
				if (kind_q == cll_pkg::KIND_INSERT) begin
					val_req.wr_en   = 1'b1;
					val_req.wr_addr = cand_q;
					val_req.wr_data = value_q;
				end
			end
			cll_pkg::ST_NEW_LINK: begin
				link_req.wr_en   = 1'b1;
				link_req.wr_addr = cand_q;
			end
			cll_pkg::ST_INS_RDPOS: begin
				link_req.rd_addr = pos_q;
			end
			cll_pkg::ST_INS_LINK: begin
				link_req.wr_en   = 1'b1;
				link_req.wr_addr = cand_q;
				link_req.wr_data = link_rd;
			end
			cll_pkg::ST_INS_HOOK: begin
				link_req.wr_en   = 1'b1;
				link_req.wr_addr = pos_q;
				link_req.wr_data = cand_q;
			end
			cll_pkg::ST_WALK_HEAD: begin
				link_req.rd_addr = head_q;
			end
			cll_pkg::ST_WALK_FIRST,
			cll_pkg::ST_WALK_CMP: begin
				// fetch link and value of the next candidate together
				link_req.rd_addr = link_rd;
				val_req.rd_addr  = link_rd;
			end
			cll_pkg::ST_DEL_BYPASS: begin
				link_req.wr_en   = 1'b1;
				link_req.wr_addr = pred_q;
				link_req.wr_data = tail_q;
			end
			cll_pkg::ST_DEL_FREE: begin
				link_req.wr_en   = 1'b1;
				link_req.wr_addr = cand_q;
				link_req.wr_data = link_rd;
			end
			cll_pkg::ST_DEL_PUSH: begin
				link_req.wr_en   = 1'b1;
				link_req.wr_data = cand_q;
			end
			cll_pkg::ST_INSPECT_RD: begin
				link_req.rd_addr = pos_q;
				val_req.rd_addr  = pos_q;
			end
			cll_pkg::ST_FIN: begin
				fin = res_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cll_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			cll_pkg::ST_IDLE: begin
				if (accept) begin
					kind_q  <= req.kind;
					value_q <= req.value;
					head_q  <= req.list_head;
					pos_q   <= req.position;
					pred_q  <= req.list_head;
					cnt_q   <= '0;
					res_q   <= '0;
				end
			end
			cll_pkg::ST_ALLOC_CHK: begin
				cand_q <= link_rd;
				if (link_zero) begin
					res_q.out_of_space <= 1'b1;
				end else begin
					res_q.cell_index <= link_rd;
				end
			end
			cll_pkg::ST_WALK_FIRST: begin
				cand_q <= link_rd;
				if (link_zero && kind_q == cll_pkg::KIND_PREV) begin
					res_q.cell_index <= pred_q;
				end
			end
			cll_pkg::ST_WALK_CMP: begin
				if (hit) begin
					tail_q <= link_rd;
					case (kind_q)
						cll_pkg::KIND_FIND:   res_q.cell_index <= cand_q;
						cll_pkg::KIND_PREV:   res_q.cell_index <= pred_q;
						cll_pkg::KIND_DELETE: res_q.removed    <= 1'b1;
						default: begin
						end
					endcase
				end else if (runaway) begin
					if (kind_q == cll_pkg::KIND_PREV) begin
						res_q.cell_index <= pred_q;
					end
				end else begin
					pred_q <= cand_q;
					cand_q <= link_rd;
					cnt_q  <= cnt_q + 1'b1;
					if (link_zero && kind_q == cll_pkg::KIND_PREV) begin
						res_q.cell_index <= cand_q;
					end
				end
			end
			cll_pkg::ST_INSPECT_RES: begin
				res_q.cell_index <= link_rd;
				res_q.cell_value <= val_rd;
				res_q.is_last    <= link_zero;
			end
			default: begin
			end
		endcase
	end

	assign res = res_q;

endmodule
`default_nettype wire

>>> rtl/cursor_linked_list_engine_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cursor_linked_list_engine_unit
// Cursor-based linked-list pool: new list, insert after, delete value, find,
// find previous and inspect cell over a shared link and value store.
// ----------------------------------------------------------------------------
//  channel | valid     | stall     | word
//  request | req_valid | req_stall | req (cll_pkg::req_word_t)
//  result  | rsp_valid | rsp_stall | rsp (cll_pkg::rsp_word_t)
//
//  One request at a time; the link memory's single read port paces the work.
//  An unknown kind goes straight from accept to the result, with an all-zero word.
//  Find and find previous visit the list one cell at a time; delete adds its unlink and free steps on a hit.
//  Reset is immediate: per-cell valid bits stand in for the initial free chain.
//  The result register lets the next request in while rsp is stalled.
// ----------------------------------------------------------------------------
module cursor_linked_list_engine_unit (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_stall,
	input  wire cll_pkg::req_word_t req,
	output logic                    rsp_valid,
	input  wire logic               rsp_stall,
	output cll_pkg::rsp_word_t      rsp
);

	cll_pkg::link_req_t         link_req;
	cll_pkg::val_req_t          val_req;
	logic [cll_pkg::IDX_W-1:0]  link_rd;
	logic [cll_pkg::DATA_W-1:0] val_rd;
	cll_pkg::rsp_word_t         res;
	cll_pkg::rsp_word_t         rsp_q;
	logic                       rsp_valid_q;
	logic                       busy;
	logic                       fin;
	logic                       accept;
	logic                       res_free;

	assign accept   = req_valid && !req_stall;
	assign res_free = !rsp_valid_q || !rsp_stall;

	cll_link_mem u_link (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (link_req),
		.rd_data (link_rd)
	);

	cll_value_mem u_value (
		.clk     (clk),
		.req     (val_req),
		.rd_data (val_rd)
	);

	cll_walk_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.req      (req),
		.link_rd  (link_rd),
		.val_rd   (val_rd),
		.res_free (res_free),
		.link_req (link_req),
		.val_req  (val_req),
		.busy     (busy),
		.fin      (fin),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fin) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			rsp_q <= res;
		end
	end

	assign req_stall = busy;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef ASSERT_OFF
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> req_stall)
		else $error("sequencer took a word without going busy");

	a_fin_into_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		fin |-> (!rsp_valid || !rsp_stall))
		else $error("result loaded over a word still waiting");

	a_removed_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.removed) |-> (rsp.cell_index == '0 && !rsp.out_of_space))
		else $error("delete result carries other fields");

	a_oos_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.out_of_space) |-> (rsp.cell_index == '0 && !rsp.removed))
		else $error("out of space result names a cell");
`endif

endmodule
`default_nettype wire

>>> tb/tb_cursor_linked_list_engine_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cursor_linked_list_engine_unit
// Sends list requests to the cell pool and checks each result word against
// a cycle-free model of the pool. The model keeps its own link and value
// stores. Directed cases run first: every request kind, extreme values,
// empty lists, misses, misuse of cell 0 and a self-linked cell that makes
// a walk run away. Later phases fill the pool until it is empty, drain it
// again, and then run random list traffic with stalls on both channels.
// ----------------------------------------------------------------------------
module tb_cursor_linked_list_engine_unit;

	typedef logic [cll_pkg::IDX_W-1:0]  idx_t;
	typedef logic [cll_pkg::DATA_W-1:0] val_t;

	// kinds that the block ignores
	localparam logic [2:0] KIND_SPARE_LO = 3'd6;
	localparam logic [2:0] KIND_SPARE_HI = 3'd7;
	localparam int MAX_LISTS     = 8;
	localparam int SETTLE_CYCLES = 200;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               req_valid = 1'b0;
	logic               req_stall;
	cll_pkg::req_word_t req       = '0;
	logic               rsp_valid;
	logic               rsp_stall = 1'b0;
	cll_pkg::rsp_word_t rsp;

	cursor_linked_list_engine_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #10 clk = ~clk;

	initial begin
		#20ms;
		$display("simulation failed");
		$finish;
	end

	// pool model
	idx_t               pool_link[cll_pkg::CELLS];
	val_t               pool_val[cll_pkg::CELLS];
	bit                 pool_set[cll_pkg::CELLS];
	cll_pkg::rsp_word_t awaited[$];
	idx_t               list_heads[$];
	idx_t               walk_cells[$];
	val_t               hot_vals[8];
	int                 mismatches = 0;
	int                 stall_left = 0;
	bit                 quiet      = 1'b0;

	// predecessor of the first cell holding v; blind marks a never-written value
	function automatic idx_t seek_prev(input val_t v, input idx_t head,
			output bit hit, output bit blind);
		idx_t p;
		idx_t nx;
		int   n;
		bit   done;
		p     = head;
		n     = 0;
		hit   = 1'b0;
		blind = 1'b0;
		done  = 1'b0;
		while (!done) begin
			nx = pool_link[p];
			if (nx == '0) begin
				done = 1'b1;
			end else begin
				if (!pool_set[nx]) blind = 1'b1;
				if (pool_val[nx] == v) begin
					hit  = 1'b1;
					done = 1'b1;
				end else if (n >= cll_pkg::CELLS) begin
					done = 1'b1;
				end else begin
					p = nx;
					n++;
				end
			end
		end
		return p;
	endfunction

	function automatic idx_t seek_match(input val_t v, input idx_t head, output bit blind);
		idx_t p;
		int   n;
		bit   done;
		p     = pool_link[head];
		n     = 0;
		blind = 1'b0;
		done  = 1'b0;
		while (!done) begin
			if (p == '0) begin
				done = 1'b1;
			end else begin
				if (!pool_set[p]) blind = 1'b1;
				if (pool_val[p] == v) begin
					done = 1'b1;
				end else if (n >= cll_pkg::CELLS) begin
					// runaway chain counts as a miss
					p    = '0;
					done = 1'b1;
				end else begin
					p = pool_link[p];
					n++;
				end
			end
		end
		return p;
	endfunction

	function automatic bit touches_blank(input cll_pkg::req_word_t w);
		idx_t p;
		bit   hit;
		bit   blind;
		blind = 1'b0;
		case (w.kind)
			cll_pkg::KIND_DELETE,
			cll_pkg::KIND_PREV:    p = seek_prev(w.value, w.list_head, hit, blind);
			cll_pkg::KIND_FIND:    p = seek_match(w.value, w.list_head, blind);
			cll_pkg::KIND_INSPECT: blind = !pool_set[w.position];
			default:               blind = 1'b0;
		endcase
		return blind;
	endfunction

	function automatic cll_pkg::rsp_word_t apply_list_op(input cll_pkg::req_word_t w);
		cll_pkg::rsp_word_t o;
		idx_t               c;
		idx_t               t;
		bit                 hit;
		bit                 blind;
		o = '0;
		case (w.kind)
			cll_pkg::KIND_NEW: begin
				c = pool_link[0];
				if (c == '0) begin
					o.out_of_space = 1'b1;
				end else begin
					pool_link[0] = pool_link[c];
					pool_link[c] = '0;
					o.cell_index = c;
				end
			end
			cll_pkg::KIND_INSERT: begin
				c = pool_link[0];
				if (c == '0) begin
					o.out_of_space = 1'b1;
				end else begin
					pool_link[0]          = pool_link[c];
					pool_val[c]           = w.value;
					pool_set[c]           = 1'b1;
					pool_link[c]          = pool_link[w.position];
					pool_link[w.position] = c;
					o.cell_index          = c;
				end
			end
			cll_pkg::KIND_DELETE: begin
				c = seek_prev(w.value, w.list_head, hit, blind);
				if (hit) begin
					t            = pool_link[c];
					pool_link[c] = pool_link[t];
					pool_link[t] = pool_link[0];
					pool_link[0] = t;
					o.removed    = 1'b1;
				end
			end
			cll_pkg::KIND_FIND: o.cell_index = seek_match(w.value, w.list_head, blind);
			cll_pkg::KIND_PREV: o.cell_index = seek_prev(w.value, w.list_head, hit, blind);
			cll_pkg::KIND_INSPECT: begin
				o.cell_index = pool_link[w.position];
				o.cell_value = pool_val[w.position];
				o.is_last    = (pool_link[w.position] == '0);
			end
			default: o = '0;
		endcase
		return o;
	endfunction

	function automatic cll_pkg::req_word_t make_word(input logic [2:0] k, input val_t v,
			input idx_t head, input idx_t spot);
		cll_pkg::req_word_t w;
		w.kind      = k;
		w.value     = v;
		w.list_head = head;
		w.position  = spot;
		return w;
	endfunction

	function automatic idx_t rand_idx();
		return idx_t'($urandom_range(0, cll_pkg::CELLS - 1));
	endfunction

	function automatic val_t pick_value();
		if ($urandom_range(0, 9) < 7) return hot_vals[3'($urandom_range(0, 7))];
		return $urandom;
	endfunction

	function automatic void gather_list(input idx_t head);
		idx_t p;
		int   n;
		walk_cells.delete();
		walk_cells.push_back(head);
		p = pool_link[head];
		n = 0;
		while (p != '0 && n < cll_pkg::CELLS) begin
			walk_cells.push_back(p);
			p = pool_link[p];
			n++;
		end
	endfunction

	task automatic flag_mismatch(input string what, input longint want, input longint got);
		$display("mismatch %s: expected %0h, got %0h at %0t", what, want, got, $time);
		mismatches++;
	endtask

	// one request word; the model steps when the word is taken
	task automatic send_word(input cll_pkg::req_word_t w, output cll_pkg::rsp_word_t pred);
		// a never-written value must not be looked at
		if (touches_blank(w)) w.kind = KIND_SPARE_LO;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		req       <= w;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		pred = apply_list_op(w);
		awaited.push_back(pred);
	endtask

	task automatic wait_settled();
		req_valid <= 1'b0;
		@(posedge clk);
		while (awaited.size() != 0) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (stall_left > 1) begin
			stall_left <= stall_left - 1;
		end else if (stall_left == 1) begin
			stall_left <= 0;
			rsp_stall  <= 1'b0;
		end else if (!quiet && $urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(1, 14);
			rsp_stall  <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cll_pkg::rsp_word_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (awaited.size() == 0) begin
				flag_mismatch("word with nothing awaited", 0, longint'(rsp));
			end else begin
				want = awaited.pop_front();
				if (rsp.cell_index !== want.cell_index)
					flag_mismatch("cell_index", longint'(want.cell_index),
						longint'(rsp.cell_index));
				if (rsp.cell_value !== want.cell_value)
					flag_mismatch("cell_value", longint'(want.cell_value),
						longint'(rsp.cell_value));
				if (rsp.is_last !== want.is_last)
					flag_mismatch("is_last", longint'(want.is_last), longint'(rsp.is_last));
				if (rsp.out_of_space !== want.out_of_space)
					flag_mismatch("out_of_space", longint'(want.out_of_space),
						longint'(rsp.out_of_space));
				if (rsp.removed !== want.removed)
					flag_mismatch("removed", longint'(want.removed), longint'(rsp.removed));
			end
		end
	end

	task automatic test_basic_ops();
		cll_pkg::rsp_word_t pred;
		idx_t               hdr;
		idx_t               a;
		idx_t               b;
		send_word(make_word(cll_pkg::KIND_NEW, '0, '0, '0), pred);
		hdr = pred.cell_index;
		list_heads.push_back(hdr);
		send_word(make_word(cll_pkg::KIND_INSERT, 32'h7fff_ffff, '0, hdr), pred);
		a = pred.cell_index;
		send_word(make_word(cll_pkg::KIND_INSERT, 32'h8000_0000, '0, hdr), pred);
		send_word(make_word(cll_pkg::KIND_INSERT, '0, '0, a), pred);
		b = pred.cell_index;
		send_word(make_word(cll_pkg::KIND_INSERT, '1, '0, b), pred);
		b = pred.cell_index;
		send_word(make_word(cll_pkg::KIND_FIND, '0, hdr, '0), pred);
		send_word(make_word(cll_pkg::KIND_FIND, 32'h0000_3039, hdr, '0), pred);
		send_word(make_word(cll_pkg::KIND_PREV, 32'h7fff_ffff, hdr, '0), pred);
		send_word(make_word(cll_pkg::KIND_PREV, 32'h5555_aaaa, hdr, '0), pred);
		send_word(make_word(cll_pkg::KIND_INSPECT, '0, '0, a), pred);
		// tail of the list
		send_word(make_word(cll_pkg::KIND_INSPECT, '0, '0, b), pred);
		send_word(make_word(cll_pkg::KIND_DELETE, 32'h8000_0000, hdr, '0), pred);
		send_word(make_word(cll_pkg::KIND_DELETE, 32'h8000_0000, hdr, '0), pred);
		send_word(make_word(cll_pkg::KIND_FIND, 32'h8000_0000, hdr, '0), pred);
		wait_settled();
	endtask

	task automatic test_corner_cases();
		cll_pkg::rsp_word_t pred;
		idx_t               hdr;
		idx_t               t;
		send_word(make_word(cll_pkg::KIND_NEW, '0, '0, '0), pred);
		hdr = pred.cell_index;
		list_heads.push_back(hdr);
		// searches of an empty list
		send_word(make_word(cll_pkg::KIND_FIND, '1, hdr, '0), pred);
		send_word(make_word(cll_pkg::KIND_PREV, '1, hdr, '0), pred);
		send_word(make_word(cll_pkg::KIND_DELETE, '1, hdr, '0), pred);
		// insert after cell 0 leaves the new cell at the head of the free chain
		send_word(make_word(cll_pkg::KIND_INSERT, 32'h1234_5678, '0, '0), pred);
		send_word(make_word(cll_pkg::KIND_INSPECT, '0, '0, pred.cell_index), pred);
		// inserting after the free head links that cell to itself
		t = pool_link[0];
		send_word(make_word(cll_pkg::KIND_INSERT, 32'h0bad_cafe, '0, t), pred);
		send_word(make_word(cll_pkg::KIND_FIND, 32'h0000_0001, t, '0), pred);
		send_word(make_word(cll_pkg::KIND_PREV, 32'h0000_0001, t, '0), pred);
		send_word(make_word(cll_pkg::KIND_DELETE, 32'h0000_0001, t, '0), pred);
		send_word(make_word(cll_pkg::KIND_DELETE, 32'h0bad_cafe, t, '0), pred);
		send_word(make_word(KIND_SPARE_LO, '1, '1, '1), pred);
		send_word(make_word(KIND_SPARE_HI, '1, '1, '1), pred);
		wait_settled();
	endtask

	task automatic test_pool_exhaustion();
		cll_pkg::rsp_word_t pred;
		idx_t               head;
		int                 n;
		n = 0;
		while (pool_link[0] != '0 && n < 2 * cll_pkg::CELLS) begin
			head = list_heads[$urandom_range(0, list_heads.size() - 1)];
			gather_list(head);
			send_word(make_word(cll_pkg::KIND_INSERT, pick_value(), rand_idx(),
				walk_cells[$urandom_range(0, walk_cells.size() - 1)]), pred);
			n++;
		end
		send_word(make_word(cll_pkg::KIND_INSERT, $urandom, '0, list_heads[0]), pred);
		send_word(make_word(cll_pkg::KIND_NEW, $urandom, '1, '1), pred);
		wait_settled();
		// hand most cells back
		for (n = 0; n < 100; n++) begin
			head = list_heads[$urandom_range(0, list_heads.size() - 1)];
			gather_list(head);
			if (walk_cells.size() > 1)
				send_word(make_word(cll_pkg::KIND_DELETE,
					pool_val[walk_cells[$urandom_range(1, walk_cells.size() - 1)]],
					head, rand_idx()), pred);
		end
		wait_settled();
	endtask

	task automatic random_list_op();
		cll_pkg::rsp_word_t pred;
		idx_t               head;
		idx_t               spot;
		idx_t               junk;
		val_t               v;
		int                 pick;
		junk = rand_idx();
		if (list_heads.size() == 0
				|| (list_heads.size() < MAX_LISTS && $urandom_range(0, 11) == 0)) begin
			send_word(make_word(cll_pkg::KIND_NEW, $urandom, junk, junk), pred);
			if (!pred.out_of_space) list_heads.push_back(pred.cell_index);
		end else begin
			head = list_heads[$urandom_range(0, list_heads.size() - 1)];
			gather_list(head);
			spot = walk_cells[$urandom_range(0, walk_cells.size() - 1)];
			v    = pick_value();
			// aim searches at a stored value most of the time
			if (walk_cells.size() > 1 && $urandom_range(0, 3) != 0)
				v = pool_val[walk_cells[$urandom_range(1, walk_cells.size() - 1)]];
			pick = $urandom_range(0, 9);
			case (pick)
				0, 1, 2: send_word(make_word(cll_pkg::KIND_INSERT, pick_value(), junk, spot),
					pred);
				3, 4:    send_word(make_word(cll_pkg::KIND_DELETE, v, head, junk), pred);
				5, 6:    send_word(make_word(cll_pkg::KIND_FIND, v, head, junk), pred);
				7:       send_word(make_word(cll_pkg::KIND_PREV, v, head, junk), pred);
				default: begin
					if (walk_cells.size() > 1)
						spot = walk_cells[$urandom_range(1, walk_cells.size() - 1)];
					send_word(make_word(cll_pkg::KIND_INSPECT, v, junk, spot), pred);
				end
			endcase
		end
	endtask

	task automatic test_random_lists(input int count);
		cll_pkg::rsp_word_t pred;
		int                 n;
		for (n = 0; n < count; n++) begin
			if ($urandom_range(0, 6) == 0)
				send_word(make_word(3'($urandom_range(0, 7)), $urandom,
					rand_idx(), rand_idx()), pred);
			else
				random_list_op();
			if (n == count / 2) wait_settled();
		end
		wait_settled();
	endtask

	task automatic test_quiet_tail(input int count);
		int n;
		quiet = 1'b1;
		for (n = 0; n < count; n++) random_list_op();
		wait_settled();
	endtask

	initial begin
		int i;
		for (i = 0; i < cll_pkg::CELLS; i++) begin
			pool_link[i] = (i == cll_pkg::CELLS - 1) ? '0 : idx_t'(i + 1);
			pool_val[i]  = '0;
			pool_set[i]  = 1'b0;
		end
		hot_vals[0] = 32'h7fff_ffff;
		hot_vals[1] = 32'h8000_0000;
		hot_vals[2] = '0;
		hot_vals[3] = '1;
		hot_vals[4] = 32'h0000_0001;
		for (i = 5; i < 8; i++) hot_vals[i] = $urandom;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic_ops();
		test_corner_cases();
		test_pool_exhaustion();
		test_random_lists(150);
		test_quiet_tail(40);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
